// ===== rtl/core/bwm_pkg.sv =====
// ----------------------------------------------------------------------------
// bwm_pkg - shared types, constants and helpers
// Sizes of the dictionary store and key buffers, request codes, result codes,
// byte classification and the control structs passed between the modules.
// ----------------------------------------------------------------------------
package bwm_pkg;

  localparam int ENTRIES = 32;
  localparam int MAX_LEN = 32;

  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int JW    = $clog2(MAX_LEN);
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DEPTH = ENTRIES * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(DEPTH + 1);

  // register byte address
  localparam logic [2:0] REG_ENABLED = 3'd0;

  typedef enum logic [2:0] {
    K_TEXT       = 3'd0,
    K_END_TEXT   = 3'd1,
    K_ENTRY_BYTE = 3'd2,
    K_END_ENTRY  = 3'd3,
    K_CLEAR      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    AK_VERDICT = 2'd0,
    AK_STATUS  = 2'd1,
    AK_CLEAR   = 2'd2
  } answer_kind_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_DUP   = 2'd1,
    ST_LONG  = 2'd2,
    ST_FULL  = 2'd3
  } entry_status_t;

  typedef struct packed {
    logic       push;
    logic       clr;
    logic [7:0] din;
  } kb_ctl_t;

  typedef struct packed {
    logic [LW-1:0] len;
    logic          over;
  } kb_stat_t;

  typedef struct packed {
    logic          dwe;
    logic [AW-1:0] daddr;
    logic [7:0]    ddata;
    logic          lwe;
    logic [EW-1:0] laddr;
    logic [LW-1:0] ldata;
  } store_wr_t;

  typedef struct packed {
    logic [1:0] answer_kind;
    logic       found;
    logic [1:0] entry_status;
    logic [5:0] entry_count;
  } result_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

endpackage

// ===== rtl/core/bwm_keybuf.sv =====
// ----------------------------------------------------------------------------
// bwm_keybuf - key byte buffer
// Appends bytes up to MAX_LEN, flags overflow beyond that, and serves one
// registered read per cycle to the compare sequencer.
// ----------------------------------------------------------------------------
module bwm_keybuf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bwm_pkg::kb_ctl_t         ctl,
  input  logic [bwm_pkg::JW-1:0]   raddr,
  output logic [7:0]               rdata,
  output bwm_pkg::kb_stat_t        stat
);

  logic [7:0]             mem_r [bwm_pkg::MAX_LEN];
  logic [7:0]             rdata_r;
  logic [bwm_pkg::LW-1:0] len_r;
  logic                   over_r;
  logic                   room;

  assign room = len_r < bwm_pkg::LW'(bwm_pkg::MAX_LEN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      over_r <= 1'b0;
    end else if (ctl.clr) begin
      len_r  <= '0;
      over_r <= 1'b0;
    end else if (ctl.push) begin
      if (room) begin
        len_r <= len_r + 1'b1;
      end else begin
        over_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clr && room) begin
      mem_r[len_r[bwm_pkg::JW-1:0]] <= ctl.din;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata     = rdata_r;
  assign stat.len  = len_r;
  assign stat.over = over_r;

endmodule

// ===== rtl/core/bwm_store.sv =====
// ----------------------------------------------------------------------------
// bwm_store - dictionary store
// Entry bytes in a flat memory at entry*MAX_LEN + offset, entry lengths in a
// second memory; both read registered, one address each per cycle.
// ----------------------------------------------------------------------------
module bwm_store (
  input  logic                     clk,
  input  bwm_pkg::store_wr_t       wr,
  input  logic [bwm_pkg::AW-1:0]   draddr,
  input  logic [bwm_pkg::EW-1:0]   lraddr,
  output logic [7:0]               ddata,
  output logic [bwm_pkg::LW-1:0]   ldata
);

  logic [7:0]             dict_mem_r [bwm_pkg::DEPTH];
  logic [bwm_pkg::LW-1:0] len_mem_r  [bwm_pkg::ENTRIES];
  logic [7:0]             ddata_r;
  logic [bwm_pkg::LW-1:0] ldata_r;

  always_ff @(posedge clk) begin
    if (wr.dwe) begin
      dict_mem_r[wr.daddr] <= wr.ddata;
    end
    ddata_r <= dict_mem_r[draddr];
  end

  always_ff @(posedge clk) begin
    if (wr.lwe) begin
      len_mem_r[wr.laddr] <= wr.ldata;
    end
    ldata_r <= len_mem_r[lraddr];
  end

  assign ddata = ddata_r;
  assign ldata = ldata_r;

endmodule

// ===== rtl/core/bwm_seq.sv =====
// ----------------------------------------------------------------------------
// bwm_seq - request sequencer and byte compare unit
// Decodes requests, walks stored entries one byte per cycle through a single
// byte comparator, copies new entries into the store and holds the result.
// ----------------------------------------------------------------------------
module bwm_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     enabled,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_kind,
  input  logic [7:0]               in_byte,
  output bwm_pkg::kb_ctl_t         wctl,
  output bwm_pkg::kb_ctl_t         pctl,
  input  bwm_pkg::kb_stat_t        wstat,
  input  bwm_pkg::kb_stat_t        pstat,
  input  logic [7:0]               wkey,
  input  logic [7:0]               pkey,
  output logic [bwm_pkg::JW-1:0]   key_raddr,
  output bwm_pkg::store_wr_t       swr,
  output logic [bwm_pkg::AW-1:0]   draddr,
  output logic [bwm_pkg::EW-1:0]   lraddr,
  input  logic [7:0]               dict_q,
  input  logic [bwm_pkg::LW-1:0]   len_q,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bwm_pkg::result_t         out_res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_COPY = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_CLOSE = 2'd0,
    OP_TEXT  = 2'd1,
    OP_ENTRY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  state_t                 state_r, state_nxt;
  op_t                    op_r, op_nxt;
  logic                   src_pend_r, src_pend_nxt;
  logic [bwm_pkg::CW-1:0] e_r, e_nxt;
  logic [bwm_pkg::JW-1:0] j_r, j_nxt;
  logic [bwm_pkg::BW-1:0] base_r, base_nxt;
  logic [bwm_pkg::CW-1:0] count_r, count_nxt;
  logic                   match_r, match_nxt;
  logic [1:0]             status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  bwm_pkg::result_t       res_r, res_nxt;

  logic                   in_fire;
  logic [bwm_pkg::LW-1:0] key_len;
  logic [7:0]             key_q;
  logic                   len_eq;
  logic                   byte_eq;
  logic                   last_byte;
  logic                   hit;
  logic                   miss;

  assign in_fire = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  assign key_len   = src_pend_r ? pstat.len : wstat.len;
  assign key_q     = src_pend_r ? pkey : wkey;
  assign len_eq    = (len_q == key_len);
  assign byte_eq   = (dict_q == key_q);
  assign last_byte = (bwm_pkg::LW'(j_r) == key_len - 1'b1);
  assign hit       = len_eq && ((key_len == '0) || (byte_eq && last_byte));
  assign miss      = !len_eq || ((key_len != '0) && !byte_eq);

  always_comb begin
    logic start_word;
    logic start_scan;
    logic fin_word;
    logic do_add;
    logic fin_add;
    start_word    = 1'b0;
    start_scan    = 1'b0;
    fin_word      = 1'b0;
    do_add        = 1'b0;
    fin_add       = 1'b0;
    state_nxt     = state_r;
    op_nxt        = op_r;
    src_pend_nxt  = src_pend_r;
    e_nxt         = e_r;
    j_nxt         = j_r;
    base_nxt      = base_r;
    count_nxt     = count_r;
    match_nxt     = match_r;
    status_nxt    = status_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wctl          = '0;
    pctl          = '0;
    swr           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          e_nxt    = '0;
          j_nxt    = '0;
          base_nxt = '0;
          unique case (in_kind)
            bwm_pkg::K_TEXT: begin
              if (bwm_pkg::is_space(in_byte)) begin
                op_nxt     = OP_CLOSE;
                start_word = 1'b1;
              end else if (bwm_pkg::is_alnum(in_byte)) begin
                wctl.push = 1'b1;
                wctl.din  = bwm_pkg::lower_byte(in_byte);
              end
            end
            bwm_pkg::K_END_TEXT: begin
              op_nxt     = OP_TEXT;
              start_word = 1'b1;
            end
            bwm_pkg::K_ENTRY_BYTE: begin
              pctl.push = 1'b1;
              pctl.din  = bwm_pkg::lower_byte(in_byte);
            end
            bwm_pkg::K_END_ENTRY: begin
              op_nxt = OP_ENTRY;
              if (pstat.over) begin
                status_nxt = bwm_pkg::ST_LONG;
                pctl.clr   = 1'b1;
                state_nxt  = S_DONE;
              end else if (count_r != '0) begin
                src_pend_nxt = 1'b1;
                start_scan   = 1'b1;
              end else begin
                do_add = 1'b1;
              end
            end
            bwm_pkg::K_CLEAR: begin
              op_nxt    = OP_CLEAR;
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
            end
          endcase
          if (start_word) begin
            if (wstat.len != '0 && !wstat.over && count_r != '0) begin
              src_pend_nxt = 1'b0;
              start_scan   = 1'b1;
            end else begin
              fin_word = 1'b1;
            end
          end
          if (start_scan) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (src_pend_r) begin
            status_nxt = bwm_pkg::ST_DUP;
            pctl.clr   = 1'b1;
            state_nxt  = S_DONE;
          end else begin
            match_nxt = 1'b1;
            fin_word  = 1'b1;
          end
        end else if (miss) begin
          base_nxt = base_r + bwm_pkg::BW'(bwm_pkg::MAX_LEN);
          j_nxt    = '0;
          if (e_r + 1'b1 == count_r) begin
            if (src_pend_r) begin
              do_add = 1'b1;
            end else begin
              fin_word = 1'b1;
            end
          end else begin
            e_nxt = e_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_COPY: begin
        swr.dwe   = 1'b1;
        swr.daddr = bwm_pkg::AW'(base_r + bwm_pkg::BW'(j_r));
        swr.ddata = pkey;
        if (bwm_pkg::LW'(j_r) == pstat.len - 1'b1) begin
          fin_add = 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          res_nxt.found       = 1'b0;
          res_nxt.entry_status = '0;
          res_nxt.entry_count = 6'(count_r);
          unique case (op_r)
            OP_TEXT: begin
              res_nxt.answer_kind = bwm_pkg::AK_VERDICT;
              res_nxt.found       = enabled && match_r;
              match_nxt           = 1'b0;
            end
            OP_ENTRY: begin
              res_nxt.answer_kind  = bwm_pkg::AK_STATUS;
              res_nxt.entry_status = status_r;
            end
            default: begin
              res_nxt.answer_kind = bwm_pkg::AK_CLEAR;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_word) begin
      wctl.clr  = 1'b1;
      state_nxt = (op_nxt == OP_TEXT) ? S_DONE : S_IDLE;
    end

    if (do_add) begin
      if (count_r >= bwm_pkg::CW'(bwm_pkg::ENTRIES)) begin
        status_nxt = bwm_pkg::ST_FULL;
        pctl.clr   = 1'b1;
        state_nxt  = S_DONE;
      end else if (pstat.len == '0) begin
        fin_add = 1'b1;
      end else begin
        j_nxt     = '0;
        state_nxt = S_COPY;
      end
    end

    if (fin_add) begin
      swr.lwe    = 1'b1;
      swr.laddr  = count_r[bwm_pkg::EW-1:0];
      swr.ldata  = pstat.len;
      count_nxt  = count_r + 1'b1;
      status_nxt = bwm_pkg::ST_ADDED;
      pctl.clr   = 1'b1;
      state_nxt  = S_DONE;
    end
  end

  assign key_raddr = j_nxt;
  assign draddr    = bwm_pkg::AW'(base_nxt + bwm_pkg::BW'(j_nxt));
  assign lraddr    = e_nxt[bwm_pkg::EW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_CLOSE;
      count_r     <= '0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      count_r     <= count_nxt;
      match_r     <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_pend_r <= src_pend_nxt;
    e_r        <= e_nxt;
    j_r        <= j_nxt;
    base_r     <= base_nxt;
    status_r   <= status_nxt;
    res_r      <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bwm_pkg::CW'(bwm_pkg::ENTRIES))
    else $error("entry count above store size");

  a_scan_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> e_r < count_r)
    else $error("scan past last stored entry");

  a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY |-> bwm_pkg::LW'(j_r) < pstat.len && !pstat.over)
    else $error("copy offset outside pending entry");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");

  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(res_r))
    else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/blocklist_word_matcher.sv =====
// ----------------------------------------------------------------------------
// blocklist_word_matcher - whole-word keyword blocklist
// Text and entry bytes are one request each. A word end or entry end walks the
// stored entries in turn, comparing leading bytes until a mismatch or a full
// hit; a hit ends the walk. An add then copies the entry's bytes into the
// store. The result is registered in the done state, and the next request is
// taken in the same cycle the result appears unless an earlier result is stalled.
// Reset (synchronous, active low) clears control and the entry count only;
// store contents stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
module blocklist_word_matcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] found, [2:1] entry_status, [8:3] entry_count
  output logic [1:0]  out_tuser,  // [1:0] answer_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                   enabled_r;
  logic                   sel_enabled;
  bwm_pkg::kb_ctl_t       wctl, pctl;
  bwm_pkg::kb_stat_t      wstat, pstat;
  logic [7:0]             wkey, pkey;
  logic [bwm_pkg::JW-1:0] key_raddr;
  bwm_pkg::store_wr_t     swr;
  logic [bwm_pkg::AW-1:0] draddr;
  logic [bwm_pkg::EW-1:0] lraddr;
  logic [7:0]             dict_q;
  logic [bwm_pkg::LW-1:0] len_q;
  bwm_pkg::result_t       res;

  assign sel_enabled = (cfg_paddr[2] == bwm_pkg::REG_ENABLED[2]);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = sel_enabled ? {31'd0, enabled_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && sel_enabled) begin
      enabled_r <= cfg_pwdata[0];
    end
  end

  bwm_keybuf u_wbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (wctl),
    .raddr (key_raddr),
    .rdata (wkey),
    .stat  (wstat)
  );

  bwm_keybuf u_pbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (pctl),
    .raddr (key_raddr),
    .rdata (pkey),
    .stat  (pstat)
  );

  bwm_store u_store (
    .clk    (clk),
    .wr     (swr),
    .draddr (draddr),
    .lraddr (lraddr),
    .ddata  (dict_q),
    .ldata  (len_q)
  );

  bwm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .enabled   (enabled_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata),
    .wctl      (wctl),
    .pctl      (pctl),
    .wstat     (wstat),
    .pstat     (pstat),
    .wkey      (wkey),
    .pkey      (pkey),
    .key_raddr (key_raddr),
    .swr       (swr),
    .draddr    (draddr),
    .lraddr    (lraddr),
    .dict_q    (dict_q),
    .len_q     (len_q),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.answer_kind;
  assign out_tdata = {7'd0, res.entry_count, res.entry_status, res.found};

endmodule
